// ----- rtl/bmh_pkg.sv -----
// Shared types and constants for the binary min-heap queue.
// Holds the command and result transaction structs and the heap entry layout.
// Standalone package with no dependencies.
package bmh_pkg;

    localparam int DEPTH_DEF = 64;
    localparam int CAP_W     = 7;
    localparam int CNT_OUT_W = 7;

    localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

    typedef enum logic [1:0] {
        CMD_INSERT  = 2'd0,
        CMD_EXTRACT = 2'd1,
        CMD_FIND    = 2'd2,
        CMD_NOP     = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_EMPTY     = 2'd2,
        ST_NOT_FOUND = 2'd3
    } t_status;

    typedef struct packed {
        logic [15:0] key;
        logic [7:0]  x;
        logic [7:0]  y;
    } t_entry;

    typedef struct packed {
        t_cmd        command;
        logic [15:0] key;
        logic [7:0]  coord_x;
        logic [7:0]  coord_y;
    } t_in_item;

    typedef struct packed {
        t_status                status;
        logic [15:0]            out_key;
        logic [7:0]             out_x;
        logic [7:0]             out_y;
        logic [CNT_OUT_W-1:0]   entry_count;
    } t_out_item;

endpackage

// ----- rtl/binary_min_heap_queue.sv -----
// Binary min-heap priority queue with insert, extract-minimum and find by coordinate.
// The heap lives in a single memory with one write and two registered read ports.
// Depends on bmh_pkg for the transaction structs, entry layout and codes.
//
//  channel   direction  handshake                 payload
//  command   in         i_valid / o_stall         i_data  (t_in_item)
//  result    out        o_valid / i_stall         o_data  (t_out_item)
//  config    in         i_cfg_valid / o_cfg_ready i_cfg_data (capacity limit)
//
// A refused insert, an empty extract and the no-op go straight to the result; insert reads one
// parent per step until a parent is not larger; extract reads both children per level until
// the entry settles or reaches the leaves, or stops at once when it empties the heap; find
// scans up to the fill. Reset is synchronous and active low and empties the heap.
// A new command is taken while the previous result still waits in the output register.
// The block stalls its command input from acceptance until the result is loaded.
module binary_min_heap_queue #(
    parameter int DEPTH = bmh_pkg::DEPTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  bmh_pkg::t_in_item           i_data,
    output logic                        o_valid,
    input  logic                        i_stall,
    output bmh_pkg::t_out_item          o_data,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [bmh_pkg::CAP_W-1:0]   i_cfg_data
);
    import bmh_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int LW = AW + 2;
    localparam int FW = (CW > CAP_W) ? CW : CAP_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_UP_RD,
        S_UP_CMP,
        S_EX_LOAD,
        S_DN_RD,
        S_DN_CMP,
        S_FIND,
        S_DONE
    } t_state;

    t_state            r_state, n_state;
    logic [CW-1:0]     r_cnt, n_cnt;
    logic [CAP_W-1:0]  r_cap, n_cap;
    logic [AW-1:0]     r_idx, n_idx;
    t_entry            r_item, n_item;
    t_entry            r_found, n_found;
    logic              r_have, n_have;
    t_status           r_status, n_status;
    logic [CW-1:0]     r_scan, n_scan;
    logic              r_pend, n_pend;
    t_out_item         r_out, n_out;
    logic              r_out_valid, n_out_valid;

    t_entry            r_mem [DEPTH];
    t_entry            r_rd_a, r_rd_b;
    logic [AW-1:0]     rd_addr_a, rd_addr_b;
    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    t_entry            wr_data;

    logic              in_acc;
    logic              full;
    logic [AW-1:0]     parent;
    logic [LW-1:0]     left_w, right_w, cnt_w;
    logic [CW-1:0]     cnt_m1;
    logic              take_l, take_r, match;
    logic [15:0]       small_key;

    assign in_acc      = i_valid && !o_stall;
    assign o_stall     = (r_state != S_IDLE);
    assign o_valid     = r_out_valid;
    assign o_data      = r_out;
    assign o_cfg_ready = 1'b1;

    // Effective capacity is the smaller of the limit register and the depth.
    assign full    = (r_cnt >= CW'(DEPTH)) || (FW'(r_cnt) >= FW'(r_cap));
    assign parent  = (r_idx - AW'(1)) >> 1;
    assign left_w  = LW'({r_idx, 1'b1});
    assign right_w = left_w + LW'(1);
    assign cnt_w   = LW'(r_cnt);
    assign cnt_m1  = r_cnt - CW'(1);

    assign take_l    = r_rd_a.key < r_item.key;
    assign small_key = take_l ? r_rd_a.key : r_item.key;
    assign take_r    = (right_w < cnt_w) && (r_rd_b.key < small_key);
    assign match     = (r_rd_a.x == r_item.x) && (r_rd_a.y == r_item.y);

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_cap       = i_cfg_valid ? i_cfg_data : r_cap;
        n_idx       = r_idx;
        n_item      = r_item;
        n_found     = r_found;
        n_have      = r_have;
        n_status    = r_status;
        n_scan      = r_scan;
        n_pend      = r_pend;
        n_out       = r_out;
        n_out_valid = r_out_valid && i_stall;
        rd_addr_a   = '0;
        rd_addr_b   = '0;
        wr_en       = 1'b0;
        wr_addr     = r_idx;
        wr_data     = r_item;

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_have   = 1'b0;
                    n_found  = '0;
                    n_status = ST_OK;
                    n_item   = '{key: i_data.key, x: i_data.coord_x, y: i_data.coord_y};
                    unique case (i_data.command)
                        CMD_INSERT: begin
                            if (full) begin
                                n_status = ST_FULL;
                                n_state  = S_DONE;
                            end else begin
                                n_idx   = r_cnt[AW-1:0];
                                n_cnt   = r_cnt + CW'(1);
                                n_state = S_UP_RD;
                            end
                        end
                        CMD_EXTRACT: begin
                            if (r_cnt == '0) begin
                                n_status = ST_EMPTY;
                                n_state  = S_DONE;
                            end else begin
                                n_cnt     = cnt_m1;
                                rd_addr_a = '0;
                                rd_addr_b = cnt_m1[AW-1:0];
                                n_state   = S_EX_LOAD;
                            end
                        end
                        CMD_FIND: begin
                            n_status = ST_NOT_FOUND;
                            n_scan   = '0;
                            n_pend   = 1'b0;
                            n_state  = S_FIND;
                        end
                        CMD_NOP: begin
                            n_state = S_DONE;
                        end
                    endcase
                end
            end
            S_UP_RD: begin
                if (r_idx == '0) begin
                    wr_en   = 1'b1;
                    n_state = S_DONE;
                end else begin
                    rd_addr_a = parent;
                    n_state   = S_UP_CMP;
                end
            end
            S_UP_CMP: begin
                wr_en = 1'b1;
                // The moving entry stays in r_item; a larger parent drops into the hole.
                if (r_rd_a.key > r_item.key) begin
                    wr_data = r_rd_a;
                    n_idx   = parent;
                    n_state = S_UP_RD;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_EX_LOAD: begin
                n_found = r_rd_a;
                n_have  = 1'b1;
                if (r_cnt == '0) begin
                    n_state = S_DONE;
                end else begin
                    n_item  = r_rd_b;
                    n_idx   = '0;
                    n_state = S_DN_RD;
                end
            end
            S_DN_RD: begin
                if (left_w >= cnt_w) begin
                    wr_en   = 1'b1;
                    n_state = S_DONE;
                end else begin
                    rd_addr_a = left_w[AW-1:0];
                    rd_addr_b = right_w[AW-1:0];
                    n_state   = S_DN_CMP;
                end
            end
            S_DN_CMP: begin
                wr_en = 1'b1;
                priority if (take_r) begin
                    wr_data = r_rd_b;
                    n_idx   = right_w[AW-1:0];
                    n_state = S_DN_RD;
                end else if (take_l) begin
                    wr_data = r_rd_a;
                    n_idx   = left_w[AW-1:0];
                    n_state = S_DN_RD;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_FIND: begin
                // One read is issued per cycle; its data is compared in the cycle after.
                priority if (r_pend && match) begin
                    n_found  = r_rd_a;
                    n_have   = 1'b1;
                    n_status = ST_OK;
                    n_state  = S_DONE;
                end else if (r_scan < r_cnt) begin
                    rd_addr_a = r_scan[AW-1:0];
                    n_scan    = r_scan + CW'(1);
                    n_pend    = 1'b1;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_valid || !i_stall) begin
                    n_out.status      = r_status;
                    n_out.out_key     = r_have ? r_found.key : 16'd0;
                    n_out.out_x       = r_have ? r_found.x : 8'd0;
                    n_out.out_y       = r_have ? r_found.y : 8'd0;
                    n_out.entry_count = CNT_OUT_W'(r_cnt);
                    n_out_valid       = 1'b1;
                    n_state           = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        r_rd_a <= r_mem[rd_addr_a];
        r_rd_b <= r_mem[rd_addr_b];
    end

    always_ff @(posedge i_clk) begin
        r_idx    <= n_idx;
        r_item   <= n_item;
        r_found  <= n_found;
        r_have   <= n_have;
        r_status <= n_status;
        r_scan   <= n_scan;
        r_out    <= n_out;
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_cap       <= CAP_RESET;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_cap       <= n_cap;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
        end
    end

`ifndef ASSERT_OFF
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> o_stall)
        else $error("command input not stalled after a transaction was accepted");

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(DEPTH))
        else $error("fill count exceeds heap depth");

    a_sift_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_UP_CMP || r_state == S_DN_CMP) |-> r_cnt != '0)
        else $error("sift step running on an empty heap");

    a_empty_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_data.status == ST_EMPTY) |-> o_data.entry_count == '0)
        else $error("empty status reported with nonzero entry count");
`endif

endmodule

// ----- sim/binary_min_heap_queue_tb.sv -----
// Self-checking testbench for binary_min_heap_queue: directed command table, then random
// phases at several capacity limits, checked against a behavioral heap model kept here.
// Depends on bmh_pkg and the binary_min_heap_queue RTL only.
`timescale 1ns / 1ps

module binary_min_heap_queue_tb;
    import bmh_pkg::*;

    localparam int HEAP_DEPTH   = DEPTH_DEF;
    localparam int DIR_N        = 23;
    localparam int PHASE_N      = 10;
    localparam int HOLD_CYCLES  = 400;
    localparam int STUCK_LIMIT  = 3000;
    localparam int SETTLE_CYCLES = 100;

    typedef struct packed {
        t_in_item  item;
        logic      typed;
        t_out_item golden;
    } t_dir_row;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_stall;
    t_in_item           i_data;
    logic               o_valid;
    logic               i_stall;
    t_out_item          o_data;
    logic               i_cfg_valid;
    logic               o_cfg_ready;
    logic [CAP_W-1:0]   i_cfg_data;

    // Behavioral copy of the heap and its capacity register.
    t_entry             heap_mirror [HEAP_DEPTH];
    int unsigned        heap_fill;
    logic [CAP_W-1:0]   cap_limit;

    t_out_item          pending_results [$];
    t_dir_row           dir_rows [DIR_N];
    logic               row_typed;
    t_out_item          row_golden;
    int                 fail_count;
    int                 stuck_cycles;
    int                 send_idle_pct;
    int                 recv_idle_pct;
    logic               hold_req;
    int                 hold_left;

    // Capacity per phase; -1 picks a random value over the full register range.
    int phase_cap [PHASE_N] = '{64, 1, 0, 127, 5, 64, 3, -1, -1, 64};
    int phase_ins [PHASE_N] = '{75, 50, 50, 60, 45, 80, 30, 55, 50, 40};
    int phase_ext [PHASE_N] = '{15, 30, 25, 25, 35, 10, 45, 30, 35, 45};
    int phase_len [PHASE_N] = '{200, 150, 120, 200, 150, 200, 200, 250, 200, 180};

    binary_min_heap_queue u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_data      (i_data),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_data      (o_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic t_out_item heap_apply(input t_in_item cmd);
        t_out_item   res;
        t_entry      tmp;
        int unsigned room;
        int unsigned idx;
        int unsigned parent;
        int unsigned lc;
        int unsigned rc;
        int unsigned pick;
        logic        moving;
        logic        hit;

        res = '0;
        res.status = ST_OK;
        room = (cap_limit < HEAP_DEPTH) ? cap_limit : HEAP_DEPTH;
        case (cmd.command)
            CMD_INSERT: begin
                if (heap_fill >= room) begin
                    res.status = ST_FULL;
                end else begin
                    heap_mirror[heap_fill] = '{cmd.key, cmd.coord_x, cmd.coord_y};
                    idx = heap_fill;
                    heap_fill++;
                    // Ties stop the climb.
                    while (idx != 0 && heap_mirror[(idx - 1) / 2].key > heap_mirror[idx].key) begin
                        parent = (idx - 1) / 2;
                        tmp = heap_mirror[parent];
                        heap_mirror[parent] = heap_mirror[idx];
                        heap_mirror[idx] = tmp;
                        idx = parent;
                    end
                end
            end
            CMD_EXTRACT: begin
                if (heap_fill == 0) begin
                    res.status = ST_EMPTY;
                end else begin
                    res.out_key = heap_mirror[0].key;
                    res.out_x = heap_mirror[0].x;
                    res.out_y = heap_mirror[0].y;
                    heap_fill--;
                    if (heap_fill != 0) begin
                        heap_mirror[0] = heap_mirror[heap_fill];
                        idx = 0;
                        moving = 1'b1;
                        // Left child is tried first; strict compares keep ties in place.
                        while (moving) begin
                            lc = 2 * idx + 1;
                            rc = 2 * idx + 2;
                            pick = idx;
                            if (lc < heap_fill && heap_mirror[lc].key < heap_mirror[idx].key)
                                pick = lc;
                            if (rc < heap_fill && heap_mirror[rc].key < heap_mirror[pick].key)
                                pick = rc;
                            if (pick == idx) begin
                                moving = 1'b0;
                            end else begin
                                tmp = heap_mirror[pick];
                                heap_mirror[pick] = heap_mirror[idx];
                                heap_mirror[idx] = tmp;
                                idx = pick;
                            end
                        end
                    end
                end
            end
            CMD_FIND: begin
                res.status = ST_NOT_FOUND;
                hit = 1'b0;
                for (int unsigned i = 0; i < heap_fill && !hit; i++) begin
                    if (heap_mirror[i].x == cmd.coord_x && heap_mirror[i].y == cmd.coord_y) begin
                        hit = 1'b1;
                        res.status = ST_OK;
                        res.out_key = heap_mirror[i].key;
                        res.out_x = heap_mirror[i].x;
                        res.out_y = heap_mirror[i].y;
                    end
                end
            end
            default: begin
            end
        endcase
        res.entry_count = heap_fill[CNT_OUT_W-1:0];
        return res;
    endfunction

    function automatic t_in_item random_command(input int ins_pct, input int ext_pct);
        t_in_item it;
        t_entry   held;
        int       roll;

        roll = $urandom_range(99);
        case ($urandom_range(3))
            0: it.key = 16'($urandom_range(15));
            1: it.key = $urandom_range(1) ? 16'hFFFF : 16'h0000;
            default: it.key = 16'($urandom_range(16'hFFFF));
        endcase
        if ($urandom_range(3) == 0) begin
            it.coord_x = 8'($urandom_range(3));
            it.coord_y = 8'($urandom_range(3));
        end else begin
            it.coord_x = 8'($urandom_range(255));
            it.coord_y = 8'($urandom_range(255));
        end
        if (roll < ins_pct) begin
            it.command = CMD_INSERT;
        end else if (roll < ins_pct + ext_pct) begin
            it.command = CMD_EXTRACT;
        end else if (roll < 97) begin
            it.command = CMD_FIND;
            // Mostly look up coordinates that are actually held.
            if (heap_fill != 0 && $urandom_range(9) < 7) begin
                held = heap_mirror[$urandom_range(heap_fill - 1)];
                it.coord_x = held.x;
                it.coord_y = held.y;
            end
        end else begin
            it.command = CMD_NOP;
        end
        return it;
    endfunction

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            fail_count++;
        end
    endtask

    // Entered and left at a falling edge; valid stays high into the next transaction.
    task automatic send_cmd(input t_in_item item);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_data <= item;
        do @(posedge i_clk); while (o_stall);
        @(negedge i_clk);
    endtask

    task automatic write_capacity(input logic [CAP_W-1:0] value);
        i_valid <= 1'b0;
        i_cfg_valid <= 1'b1;
        i_cfg_data <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        cap_limit = value;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic drain_results;
        i_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Receiver: random stalls, or one long hold-off counted here.
    always @(negedge i_clk) begin
        if (hold_req) begin
            hold_left = HOLD_CYCLES;
            hold_req = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_stall <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // Predict on every accepted command, check every accepted result, watch for hangs.
    always @(posedge i_clk) begin
        t_out_item want;
        t_out_item predicted;

        if (i_rst_n) begin
            if (i_valid && !o_stall) begin
                predicted = heap_apply(i_data);
                pending_results.push_back(row_typed ? row_golden : predicted);
            end
            if (o_valid && !i_stall) begin
                if (pending_results.size() == 0) begin
                    $error("unexpected result transaction: status %0d key %0d",
                           o_data.status, o_data.out_key);
                    fail_count++;
                end else begin
                    want = pending_results.pop_front();
                    check_field("status", want.status, o_data.status);
                    check_field("out_key", want.out_key, o_data.out_key);
                    check_field("out_x", want.out_x, o_data.out_x);
                    check_field("out_y", want.out_y, o_data.out_y);
                    check_field("entry_count", want.entry_count, o_data.entry_count);
                end
            end
        end
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || (i_cfg_valid && o_cfg_ready))
            stuck_cycles = 0;
        else
            stuck_cycles++;
        if (stuck_cycles >= STUCK_LIMIT) begin
            $display("FAIL binary_min_heap_queue");
            $finish;
        end
    end

    initial begin
        int cap_val;

        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_data = '0;
        i_stall = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_data = '0;
        row_typed = 1'b0;
        row_golden = '0;
        fail_count = 0;
        stuck_cycles = 0;
        hold_req = 1'b0;
        hold_left = 0;
        send_idle_pct = 29;
        recv_idle_pct = 71;
        heap_fill = 0;
        cap_limit = CAP_RESET;

        // Typed rows are plain to read off: empty heap, extremes, misses, the no-op code.
        dir_rows = '{
            '{'{CMD_EXTRACT, 16'h0000, 8'h00, 8'h00}, 1'b1, '{ST_EMPTY, 16'h0, 8'h0, 8'h0, 7'd0}},
            '{'{CMD_FIND, 16'h0000, 8'h00, 8'h00}, 1'b1, '{ST_NOT_FOUND, 16'h0, 8'h0, 8'h0, 7'd0}},
            '{'{CMD_NOP, 16'hFFFF, 8'hFF, 8'hFF}, 1'b1, '{ST_OK, 16'h0, 8'h0, 8'h0, 7'd0}},
            '{'{CMD_INSERT, 16'hFFFF, 8'hFF, 8'hFF}, 1'b1, '{ST_OK, 16'h0, 8'h0, 8'h0, 7'd1}},
            '{'{CMD_INSERT, 16'h0000, 8'h00, 8'h00}, 1'b1, '{ST_OK, 16'h0, 8'h0, 8'h0, 7'd2}},
            '{'{CMD_INSERT, 16'h8000, 8'h80, 8'h01}, 1'b0, '0},
            '{'{CMD_INSERT, 16'h8000, 8'h01, 8'h80}, 1'b0, '0},
            '{'{CMD_INSERT, 16'h0000, 8'h55, 8'hAA}, 1'b0, '0},
            '{'{CMD_INSERT, 16'h0007, 8'h80, 8'h01}, 1'b0, '0},
            '{'{CMD_FIND, 16'h0000, 8'hFF, 8'hFF}, 1'b1, '{ST_OK, 16'hFFFF, 8'hFF, 8'hFF, 7'd6}},
            '{'{CMD_FIND, 16'hFFFF, 8'h12, 8'h34}, 1'b1, '{ST_NOT_FOUND, 16'h0, 8'h0, 8'h0, 7'd6}},
            '{'{CMD_FIND, 16'h0000, 8'h80, 8'h01}, 1'b0, '0},
            '{'{CMD_EXTRACT, 16'hFFFF, 8'hFF, 8'hFF}, 1'b1, '{ST_OK, 16'h0, 8'h0, 8'h0, 7'd5}},
            '{'{CMD_EXTRACT, 16'h0000, 8'h00, 8'h00}, 1'b0, '0},
            '{'{CMD_INSERT, 16'h0001, 8'hAA, 8'h55}, 1'b0, '0},
            '{'{CMD_NOP, 16'h0000, 8'h00, 8'h00}, 1'b1, '{ST_OK, 16'h0, 8'h0, 8'h0, 7'd5}},
            '{'{CMD_EXTRACT, 16'h0000, 8'h00, 8'h00}, 1'b0, '0},
            '{'{CMD_EXTRACT, 16'h0000, 8'h00, 8'h00}, 1'b0, '0},
            '{'{CMD_EXTRACT, 16'h0000, 8'h00, 8'h00}, 1'b0, '0},
            '{'{CMD_EXTRACT, 16'h0000, 8'h00, 8'h00}, 1'b0, '0},
            '{'{CMD_EXTRACT, 16'h0000, 8'h00, 8'h00}, 1'b0, '0},
            '{'{CMD_EXTRACT, 16'h0000, 8'h00, 8'h00}, 1'b1, '{ST_EMPTY, 16'h0, 8'h0, 8'h0, 7'd0}},
            '{'{CMD_FIND, 16'h0000, 8'hFF, 8'hFF}, 1'b1, '{ST_NOT_FOUND, 16'h0, 8'h0, 8'h0, 7'd0}}
        };

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        for (int r = 0; r < DIR_N; r++) begin
            row_typed = dir_rows[r].typed;
            row_golden = dir_rows[r].golden;
            send_cmd(dir_rows[r].item);
        end
        row_typed = 1'b0;
        drain_results;

        for (int p = 0; p < PHASE_N; p++) begin
            drain_results;
            if (p < 4) begin
                send_idle_pct = 29;
                recv_idle_pct = 71;
            end else if (p < 7) begin
                send_idle_pct = 71;
                recv_idle_pct = 29;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            cap_val = (phase_cap[p] < 0) ? $urandom_range(127) : phase_cap[p];
            write_capacity(CAP_W'(cap_val));
            // Long receiver hold-off while commands keep coming, so the input backs up.
            if (p == 5) begin
                @(posedge i_clk);
                hold_req = 1'b1;
                @(negedge i_clk);
            end
            for (int n = 0; n < phase_len[p]; n++)
                send_cmd(random_command(phase_ins[p], phase_ext[p]));
        end

        drain_results;
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (fail_count == 0)
            $display("PASS binary_min_heap_queue");
        else
            $display("FAIL binary_min_heap_queue");
        $finish;
    end

endmodule

// ----- binary_min_heap_queue.f -----
rtl/bmh_pkg.sv
rtl/binary_min_heap_queue.sv
sim/binary_min_heap_queue_tb.sv
